>>> sv/tmse_pkg.sv
// Shared types, widths and codes for the Turing machine step engine.
package tmse_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_SYMBOLS = 16;
    localparam int TAPE_CELLS  = 1024;

    localparam int STATE_W    = $clog2(NUM_STATES);
    localparam int SYM_W      = $clog2(NUM_SYMBOLS);
    localparam int HEAD_W     = $clog2(TAPE_CELLS);
    localparam int LEN_W      = HEAD_W + 1;
    localparam int RULE_AW    = STATE_W + SYM_W;
    localparam int RULE_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int CMD_W      = 3;
    localparam int MOVE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 32;
    localparam int CELL_W     = 4;
    localparam int NUM_CELLS  = COUNT_W / CELL_W;

    localparam logic [CMD_W-1:0] CMD_LOAD_RULE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_CELL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd4;

    localparam logic [MOVE_W-1:0] MOVE_STAY = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_R    = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_L    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALTING_STATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_SYMBOL  = 2'd2;

    localparam logic [STATE_W-1:0] INITIAL_STATE_RESET = 4'd0;
    localparam logic [STATE_W-1:0] HALTING_STATE_RESET = 4'd15;
    localparam logic [SYM_W-1:0]   BLANK_SYMBOL_RESET  = 4'd0;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [STATE_W-1:0] rule_state;
        logic [SYM_W-1:0]   rule_symbol;
        logic               rule_defined;
        logic [SYM_W-1:0]   write_symbol;
        logic [MOVE_W-1:0]  move_code;
        logic [STATE_W-1:0] next_state;
        logic [HEAD_W-1:0]  cell_index;
        logic [SYM_W-1:0]   cell_symbol;
        logic [HEAD_W-1:0]  head_start;
        logic [LEN_W-1:0]   tape_length;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0] current_state;
        logic [SYM_W-1:0]   current_symbol;
        logic [HEAD_W-1:0]  head_position;
        logic [COUNT_W-1:0] step_count;
        logic               halted;
        logic               tape_overflow;
    } result_t;

    typedef struct packed {
        logic [SYM_W-1:0]   write_symbol;
        logic [MOVE_W-1:0]  move_code;
        logic [STATE_W-1:0] next_state;
    } rule_t;

    typedef struct packed {
        logic clear;
        logic inc;
    } cnt_ctrl_t;

    function automatic logic in_extent(input logic [HEAD_W-1:0] h,
                                       input logic [LEN_W-1:0]  lo,
                                       input logic [LEN_W-1:0]  hi);
        logic [LEN_W-1:0] hx;
        hx = {1'b0, h};
        return (hx >= lo) && (hx < hi);
    endfunction

endpackage

>>> sv/tmse_count_cell.sv
// One digit cell of the saturating step counter chain.
module tmse_count_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       carry_in,
    input  logic                       ones_in,
    output logic                       carry_out,
    output logic                       ones_out,
    output logic [tmse_pkg::CELL_W-1:0] value
);
    import tmse_pkg::*;

    logic [CELL_W-1:0] digit_reg;
    logic [CELL_W-1:0] digit_next;
    logic              digit_full;

    assign digit_full = (digit_reg == {CELL_W{1'b1}});
    assign carry_out  = carry_in & digit_full;
    assign ones_out   = ones_in & digit_full;
    assign value      = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (clear)
        begin
            digit_next = '0;
        end
        else if (carry_in)
        begin
            digit_next = digit_reg + CELL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

>>> sv/tmse_step_counter.sv
// Saturating step counter built as a chain of digit cells.
module tmse_step_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmse_pkg::cnt_ctrl_t          ctrl,
    output logic [tmse_pkg::COUNT_W-1:0] count
);
    import tmse_pkg::*;

    logic [NUM_CELLS:0] carry;
    logic [NUM_CELLS:0] ones;

    // hold at all ones: the full flag ripples independently of the carry
    assign ones[0]  = 1'b1;
    assign carry[0] = ctrl.inc & ~ones[NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        tmse_count_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (ctrl.clear),
            .carry_in  (carry[i]),
            .ones_in   (ones[i]),
            .carry_out (carry[i+1]),
            .ones_out  (ones[i+1]),
            .value     (count[i*CELL_W +: CELL_W])
        );
    end

endmodule

>>> sv/turing_machine_step_engine.sv
// Top level: command sequencer, rule table, tape store and result register.
// Sequencing: an accepted step passes S_RULE (rule table read), S_EXEC and S_FIN before result_valid
//   is registered; other commands skip S_RULE, a step while halted skips S_EXEC, and a stalled
//   result beat holds the sequencer in S_FIN until it drains. No new command is accepted until
//   the sequencer is back in S_IDLE; the tape read precedes the dependent rule table read.
// Reset: control, machine state and rule valid bits clear at once; tape cells need no clearing.
module turing_machine_step_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  tmse_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output tmse_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmse_pkg::SYM_W-1:0]     cfg_data
);
    import tmse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RULE = 4'b0010,
        S_EXEC = 4'b0100,
        S_FIN  = 4'b1000
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    item_t              item_reg;

    logic [STATE_W-1:0] initial_reg, halting_reg;
    logic [SYM_W-1:0]   blank_reg;

    logic [STATE_W-1:0] mstate_reg, mstate_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [LEN_W-1:0]   ext_lo_reg, ext_lo_next;
    logic [LEN_W-1:0]   ext_hi_reg, ext_hi_next;
    logic               overflow_reg, overflow_next;
    logic               fwd_reg, fwd_next;
    logic [SYM_W-1:0]   fwd_sym_reg, fwd_sym_next;

    logic [SYM_W-1:0]   tape_mem [TAPE_CELLS];
    logic [SYM_W-1:0]   tape_rd_reg;
    logic               tape_we, tape_re;
    logic [HEAD_W-1:0]  tape_waddr, tape_raddr;
    logic [SYM_W-1:0]   tape_wdata;

    rule_t              rule_mem [RULE_DEPTH];
    rule_t              rule_rd_reg;
    logic               rule_vld_reg [RULE_DEPTH];
    logic               rule_vld_rd_reg;
    logic               rule_we, rule_re;
    logic [RULE_AW-1:0] rule_waddr, rule_raddr;

    cnt_ctrl_t          cnt_ctrl;
    logic [COUNT_W-1:0] step_count;

    logic               accept;
    logic               out_free;
    logic [SYM_W-1:0]   sym_cur;
    logic [SYM_W-1:0]   sym_fin;
    logic [HEAD_W-1:0]  start_head;
    logic [LEN_W-1:0]   start_len;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    assign accept     = item_valid & ~item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_free   = ~result_valid_reg | ~result_stall;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign sym_cur = in_extent(head_reg, ext_lo_reg, ext_hi_reg) ? tape_rd_reg : blank_reg;
    assign sym_fin = in_extent(head_reg, ext_lo_reg, ext_hi_reg)
                   ? (fwd_reg ? fwd_sym_reg : tape_rd_reg) : blank_reg;

    assign start_head = (item_reg.head_start == '0) ? HEAD_W'(1) : item_reg.head_start;
    assign start_len  = (item_reg.tape_length > LEN_W'(TAPE_CELLS))
                      ? LEN_W'(TAPE_CELLS) : item_reg.tape_length;

    always_comb
    begin
        state_next    = state_reg;
        mstate_next   = mstate_reg;
        head_next     = head_reg;
        ext_lo_next   = ext_lo_reg;
        ext_hi_next   = ext_hi_reg;
        overflow_next = overflow_reg;
        fwd_next      = fwd_reg;
        fwd_sym_next  = fwd_sym_reg;
        cnt_ctrl      = '0;
        tape_we       = 1'b0;
        tape_waddr    = head_reg;
        tape_wdata    = item_reg.cell_symbol;
        tape_re       = 1'b0;
        tape_raddr    = head_reg;
        rule_we       = 1'b0;
        rule_waddr    = {item_reg.rule_state, item_reg.rule_symbol};
        rule_re       = 1'b0;
        rule_raddr    = {mstate_reg, sym_cur};
        result_next       = result_reg;
        result_valid_next = result_valid_reg & result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                // fetch the cell under the head for every command
                if (accept)
                begin
                    tape_re    = 1'b1;
                    fwd_next   = 1'b0;
                    state_next = (item.command == CMD_STEP) ? S_RULE : S_EXEC;
                end
            end
            S_RULE:
            begin
                if (mstate_reg == halting_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rule_re    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                unique case (item_reg.command)
                    CMD_LOAD_RULE:
                    begin
                        rule_we = 1'b1;
                    end
                    CMD_WRITE_CELL:
                    begin
                        tape_we    = 1'b1;
                        tape_waddr = item_reg.cell_index;
                        if (item_reg.cell_index == head_reg)
                        begin
                            fwd_next     = 1'b1;
                            fwd_sym_next = item_reg.cell_symbol;
                        end
                    end
                    CMD_START:
                    begin
                        mstate_next    = initial_reg;
                        head_next      = start_head;
                        ext_lo_next    = '0;
                        ext_hi_next    = start_len;
                        overflow_next  = 1'b0;
                        cnt_ctrl.clear = 1'b1;
                        tape_re        = 1'b1;
                        tape_raddr     = start_head;
                    end
                    CMD_STEP:
                    begin
                        if (!rule_vld_rd_reg)
                        begin
                            mstate_next = halting_reg;
                        end
                        else
                        begin
                            tape_we      = 1'b1;
                            tape_wdata   = rule_rd_reg.write_symbol;
                            cnt_ctrl.inc = 1'b1;
                            mstate_next  = rule_rd_reg.next_state;
                            if ({1'b0, head_reg} < ext_lo_reg)
                            begin
                                ext_lo_next = {1'b0, head_reg};
                            end
                            if ({1'b0, head_reg} >= ext_hi_reg)
                            begin
                                ext_hi_next = {1'b0, head_reg} + LEN_W'(1);
                            end
                            if (rule_rd_reg.move_code == MOVE_R)
                            begin
                                if (head_reg == '0)
                                begin
                                    overflow_next = 1'b1;
                                    mstate_next   = halting_reg;
                                end
                                else
                                begin
                                    head_next = head_reg - HEAD_W'(1);
                                end
                            end
                            else if (rule_rd_reg.move_code == MOVE_L)
                            begin
                                if (head_reg == HEAD_W'(TAPE_CELLS - 1))
                                begin
                                    overflow_next = 1'b1;
                                    mstate_next   = halting_reg;
                                end
                                else
                                begin
                                    head_next = head_reg + HEAD_W'(1);
                                end
                            end
                        end
                        // read the new head cell; bypass the write when it lands on it
                        tape_re    = 1'b1;
                        tape_raddr = head_next;
                        if (rule_vld_rd_reg && (head_next == head_reg))
                        begin
                            fwd_next     = 1'b1;
                            fwd_sym_next = rule_rd_reg.write_symbol;
                        end
                    end
                    CMD_STOP:
                    begin
                        mstate_next = halting_reg;
                    end
                    default:
                    begin
                        mstate_next = mstate_reg;
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    result_next.current_state  = mstate_reg;
                    result_next.current_symbol = sym_fin;
                    result_next.head_position  = head_reg;
                    result_next.step_count     = step_count;
                    result_next.halted         = (mstate_reg == halting_reg);
                    result_next.tape_overflow  = overflow_reg;
                    result_valid_next          = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    tmse_step_counter u_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cnt_ctrl),
        .count (step_count)
    );

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_re)
        begin
            tape_rd_reg <= tape_mem[tape_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[rule_waddr] <= rule_t'{item_reg.write_symbol, item_reg.move_code,
                                            item_reg.next_state};
        end
        if (rule_re)
        begin
            rule_rd_reg <= rule_mem[rule_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RULE_DEPTH; i++)
            begin
                rule_vld_reg[i] <= 1'b0;
            end
            rule_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (rule_we)
            begin
                rule_vld_reg[rule_waddr] <= item_reg.rule_defined;
            end
            if (rule_re)
            begin
                rule_vld_rd_reg <= rule_vld_reg[rule_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mstate_reg       <= '0;
            head_reg         <= '0;
            ext_lo_reg       <= '0;
            ext_hi_reg       <= '0;
            overflow_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            fwd_sym_reg      <= '0;
            result_valid_reg <= 1'b0;
            initial_reg      <= INITIAL_STATE_RESET;
            halting_reg      <= HALTING_STATE_RESET;
            blank_reg        <= BLANK_SYMBOL_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            mstate_reg       <= mstate_next;
            head_reg         <= head_next;
            ext_lo_reg       <= ext_lo_next;
            ext_hi_reg       <= ext_hi_next;
            overflow_reg     <= overflow_next;
            fwd_reg          <= fwd_next;
            fwd_sym_reg      <= fwd_sym_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_INITIAL_STATE)
                begin
                    initial_reg <= cfg_data;
                end
                if (cfg_index == CFG_HALTING_STATE)
                begin
                    halting_reg <= cfg_data;
                end
                if (cfg_index == CFG_BLANK_SYMBOL)
                begin
                    blank_reg <= cfg_data;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_route_by_command: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg == S_RULE) == $past(item.command == CMD_STEP)))
        else $error("sequencer took the wrong path for the accepted command");

    a_edge_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && item_reg.command == CMD_STEP && rule_vld_rd_reg &&
         rule_rd_reg.move_code == MOVE_R && head_reg == '0)
        |=> (overflow_reg && mstate_reg == halting_reg && head_reg == '0))
        else $error("move off the low tape end did not flag overflow and halt");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && item_reg.command != CMD_START)
        |=> (step_count >= $past(step_count)))
        else $error("step count went backward outside a start command");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the Turing machine step engine with a built-in machine predictor.
`timescale 1ns / 1ps

module tb_top;
    import tmse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SPARSE_IDLE = 11;
    localparam int HEAVY_IDLE  = 72;
    localparam int CHUNKS      = 6;
    localparam int CHUNK_ITEMS = 52;
    localparam int TAPE_FILL   = 128;
    localparam int HEAD_REACH  = 90;
    localparam logic [MOVE_W-1:0] MOVE_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SYM_W-1:0]     cfg_data = '0;

    turing_machine_step_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Predicted machine: registers, rule table and tape.
    logic [STATE_W-1:0] set_initial;
    logic [STATE_W-1:0] set_halting;
    logic [SYM_W-1:0]   set_blank;
    logic [STATE_W-1:0] m_state;
    logic [HEAD_W-1:0]  m_head;
    logic [LEN_W-1:0]   m_ext_lo;
    logic [LEN_W-1:0]   m_ext_hi;
    logic [COUNT_W-1:0] m_steps;
    logic               m_ovf;
    logic               rule_known [RULE_DEPTH];
    rule_t              rule_mem [RULE_DEPTH];
    logic [SYM_W-1:0]   tape_mem [TAPE_CELLS];

    item_t   commands_to_send [$];
    result_t status_due [$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int unsigned cycle_count = 0;

    function automatic logic [SYM_W-1:0] symbol_under_head();
        if ({1'b0, m_head} >= m_ext_lo && {1'b0, m_head} < m_ext_hi)
            return tape_mem[m_head];
        return set_blank;
    endfunction

    function automatic void enqueue_command(input item_t it);
        commands_to_send.insert(commands_to_send.size(), it);
    endfunction

    function automatic void advance_machine(input item_t it);
        logic [SYM_W-1:0]   sym;
        logic [RULE_AW-1:0] idx;
        rule_t              r;
        result_t            status;
        case (it.command)
            CMD_LOAD_RULE:
            begin
                rule_known[{it.rule_state, it.rule_symbol}] = it.rule_defined;
                rule_mem[{it.rule_state, it.rule_symbol}] =
                    {it.write_symbol, it.move_code, it.next_state};
            end
            CMD_WRITE_CELL:
                tape_mem[it.cell_index] = it.cell_symbol;
            CMD_START:
            begin
                m_state  = set_initial;
                m_head   = (it.head_start == '0) ? HEAD_W'(1) : it.head_start;
                m_ext_lo = '0;
                m_ext_hi = (it.tape_length > TAPE_CELLS) ? LEN_W'(TAPE_CELLS) : it.tape_length;
                m_steps  = '0;
                m_ovf    = 1'b0;
            end
            CMD_STEP:
            if (m_state != set_halting)
            begin
                sym = symbol_under_head();
                idx = {m_state, sym};
                if (!rule_known[idx])
                begin
                    m_state = set_halting;
                end
                else
                begin
                    r = rule_mem[idx];
                    tape_mem[m_head] = r.write_symbol;
                    if ({1'b0, m_head} < m_ext_lo)
                        m_ext_lo = {1'b0, m_head};
                    if ({1'b0, m_head} >= m_ext_hi)
                        m_ext_hi = {1'b0, m_head} + 1'b1;
                    m_state = r.next_state;
                    // Hold the head at either end and halt with overflow.
                    if (r.move_code == MOVE_R)
                    begin
                        if (m_head == '0)
                        begin
                            m_ovf   = 1'b1;
                            m_state = set_halting;
                        end
                        else
                            m_head = m_head - 1'b1;
                    end
                    else if (r.move_code == MOVE_L)
                    begin
                        if (m_head == TAPE_CELLS - 1)
                        begin
                            m_ovf   = 1'b1;
                            m_state = set_halting;
                        end
                        else
                            m_head = m_head + 1'b1;
                    end
                    if (m_steps != '1)
                        m_steps = m_steps + 1'b1;
                end
            end
            CMD_STOP:
                m_state = set_halting;
            default:
            begin
            end
        endcase
        status.current_state  = m_state;
        status.current_symbol = symbol_under_head();
        status.head_position  = m_head;
        status.step_count     = m_steps;
        status.halted         = (m_state == set_halting);
        status.tape_overflow  = m_ovf;
        status_due.insert(status_due.size(), status);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_status(input result_t got);
        result_t want;
        if (status_due.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result beat %h", got));
        end
        else
        begin
            want = status_due.pop_front();
            if (got.current_state !== want.current_state)
                flag_mismatch($sformatf("current_state %h, want %h",
                                        got.current_state, want.current_state));
            if (got.current_symbol !== want.current_symbol)
                flag_mismatch($sformatf("current_symbol %h, want %h",
                                        got.current_symbol, want.current_symbol));
            if (got.head_position !== want.head_position)
                flag_mismatch($sformatf("head_position %0d, want %0d",
                                        got.head_position, want.head_position));
            if (got.step_count !== want.step_count)
                flag_mismatch($sformatf("step_count %0d, want %0d",
                                        got.step_count, want.step_count));
            if (got.halted !== want.halted)
                flag_mismatch($sformatf("halted %b, want %b", got.halted, want.halted));
            if (got.tape_overflow !== want.tape_overflow)
                flag_mismatch($sformatf("tape_overflow %b, want %b",
                                        got.tape_overflow, want.tape_overflow));
        end
    endtask

    // Command driver: predict each beat as it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
                advance_machine(item);
            if (commands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item       <= commands_to_send.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Status monitor with random backpressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_status(result);
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic item_t noise_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(item_t)-1:0];
    endfunction

    task automatic send_rule(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sym,
                             input logic def, input logic [SYM_W-1:0] wsym,
                             input logic [MOVE_W-1:0] mv, input logic [STATE_W-1:0] nst);
        item_t it;
        it = noise_item();
        it.command      = CMD_LOAD_RULE;
        it.rule_state   = st;
        it.rule_symbol  = sym;
        it.rule_defined = def;
        it.write_symbol = wsym;
        it.move_code    = mv;
        it.next_state   = nst;
        enqueue_command(it);
    endtask

    task automatic send_cell(input logic [HEAD_W-1:0] idx, input logic [SYM_W-1:0] sym);
        item_t it;
        it = noise_item();
        it.command     = CMD_WRITE_CELL;
        it.cell_index  = idx;
        it.cell_symbol = sym;
        enqueue_command(it);
    endtask

    task automatic send_start(input logic [HEAD_W-1:0] hs, input logic [LEN_W-1:0] tl);
        item_t it;
        it = noise_item();
        it.command     = CMD_START;
        it.head_start  = hs;
        it.tape_length = tl;
        enqueue_command(it);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd);
        item_t it;
        it = noise_item();
        it.command = cmd;
        enqueue_command(it);
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (commands_to_send.size() != 0 || item_valid || status_due.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [SYM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INITIAL_STATE: set_initial = val;
            CFG_HALTING_STATE: set_halting = val;
            CFG_BLANK_SYMBOL:  set_blank   = val;
            default:
            begin
            end
        endcase
    endtask

    // Mostly programs: a few rules around a small state pool, a start, then steps.
    // Heads start low, inside the part of the tape that was loaded up front.
    task automatic queue_programs(input int n_items);
        int made;
        int n;
        logic [STATE_W-1:0] pool [4];
        logic [MOVE_W-1:0]  mv;
        logic [HEAD_W-1:0]  hs;
        logic [LEN_W-1:0]   tl;
        item_t              it;
        made = 0;
        pool[0] = set_initial;
        for (int i = 1; i < 4; i++)
            pool[i] = STATE_W'($urandom_range(0, NUM_STATES - 1));
        while (made < n_items)
        begin
            if ($urandom_range(99) < 75)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(9) < 8)
                        mv = $urandom_range(1) ? MOVE_R : MOVE_L;
                    else
                        mv = MOVE_W'($urandom_range(0, (1 << MOVE_W) - 1));
                    send_rule(pool[$urandom_range(3)],
                              SYM_W'($urandom_range(0, NUM_SYMBOLS - 1)),
                              $urandom_range(9) != 0,
                              SYM_W'($urandom_range(0, NUM_SYMBOLS - 1)), mv,
                              ($urandom_range(9) == 0)
                                  ? STATE_W'($urandom_range(0, NUM_STATES - 1))
                                  : pool[$urandom_range(3)]);
                end
                if ($urandom_range(3) == 0)
                begin
                    send_cell(HEAD_W'($urandom_range(0, 63)),
                              SYM_W'($urandom_range(0, NUM_SYMBOLS - 1)));
                    made++;
                end
                hs = ($urandom_range(9) == 0) ? HEAD_W'($urandom_range(0, HEAD_REACH))
                                              : HEAD_W'($urandom_range(0, 40));
                tl = ($urandom_range(7) == 0) ? LEN_W'($urandom_range(0, (1 << LEN_W) - 1))
                                              : LEN_W'($urandom_range(0, 60));
                send_start(hs, tl);
                made += n + 1;
                n = $urandom_range(2, 14);
                repeat (n) send_cmd(CMD_STEP);
                made += n;
                if ($urandom_range(4) == 0)
                begin
                    send_cmd(CMD_STOP);
                    made++;
                end
            end
            else
            begin
                it = noise_item();
                if (it.command == CMD_START)
                    it.head_start = HEAD_W'($urandom_range(0, HEAD_REACH));
                enqueue_command(it);
                made++;
            end
        end
    endtask

    initial
    begin
        logic [CMD_W-1:0]   spare;
        logic [STATE_W-1:0] ini;
        logic [STATE_W-1:0] hlt;
        logic [SYM_W-1:0]   blk;

        set_initial = INITIAL_STATE_RESET;
        set_halting = HALTING_STATE_RESET;
        set_blank   = BLANK_SYMBOL_RESET;
        m_state  = '0;
        m_head   = '0;
        m_ext_lo = '0;
        m_ext_hi = '0;
        m_steps  = '0;
        m_ovf    = 1'b0;
        for (int i = 0; i < RULE_DEPTH; i++)
        begin
            rule_known[i] = 1'b0;
            rule_mem[i]   = '0;
        end
        for (int i = 0; i < TAPE_CELLS; i++)
            tape_mem[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = SPARSE_IDLE;
        recv_idle_pct = HEAVY_IDLE;

        // Steps on the reset machine: one defined move, then an undefined rule, then halted.
        send_rule(4'd0, 4'd0, 1'b1, 4'd5, MOVE_L, 4'd3);
        send_cmd(CMD_STEP);
        send_cmd(CMD_STEP);
        send_cmd(CMD_STEP);

        // Load the low part of the tape once; the random programs start their heads inside it.
        for (int i = 0; i < TAPE_FILL; i++)
            send_cell(HEAD_W'(i), SYM_W'($urandom_range(0, NUM_SYMBOLS - 1)));

        send_cell(HEAD_W'(TAPE_CELLS - 1), '1);
        send_cell(HEAD_W'(1), 4'd7);
        send_cell('0, 4'd9);
        spare = CMD_STOP;
        do
        begin
            spare++;
            send_cmd(spare);
        end
        while (spare != '1);

        // Step off the high end of the tape, then step while halted.
        send_rule(4'd0, 4'd15, 1'b1, 4'd10, MOVE_L, 4'd5);
        send_start(HEAD_W'(TAPE_CELLS - 1), LEN_W'(TAPE_CELLS));
        send_cmd(CMD_STEP);
        send_cmd(CMD_STEP);

        // Zero head start and oversized tape length; walk off the low end.
        send_rule(4'd0, 4'd7, 1'b1, 4'd3, MOVE_R, 4'd0);
        send_rule(4'd0, 4'd9, 1'b1, 4'd9, MOVE_R, 4'd2);
        send_start('0, '1);
        send_cmd(CMD_STEP);
        send_cmd(CMD_STEP);

        // Spare move code acts as stay; head starts past an empty extent.
        send_rule(4'd0, 4'd0, 1'b1, 4'd4, MOVE_SPARE, 4'd0);
        send_start(HEAD_W'(5), '0);
        send_cmd(CMD_STEP);
        send_rule(4'd0, 4'd4, 1'b0, '1, MOVE_STAY, '1);
        send_cmd(CMD_STEP);
        send_start(HEAD_W'(2), LEN_W'(3));
        send_cmd(CMD_STOP);

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            wait_until_drained();
            if (chunk < 2)
            begin
                send_idle_pct = SPARSE_IDLE;
                recv_idle_pct = HEAVY_IDLE;
            end
            else if (chunk < 4)
            begin
                send_idle_pct = HEAVY_IDLE;
                recv_idle_pct = SPARSE_IDLE;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (chunk)
                0:
                begin
                    ini = '0;
                    hlt = '1;
                    blk = '0;
                end
                1:
                begin
                    ini = '1;
                    hlt = '0;
                    blk = '1;
                end
                2:
                begin
                    // Start lands directly in the halting state.
                    ini = STATE_W'($urandom_range(0, NUM_STATES - 1));
                    hlt = ini;
                    blk = SYM_W'($urandom_range(0, NUM_SYMBOLS - 1));
                end
                default:
                begin
                    ini = STATE_W'($urandom_range(0, NUM_STATES - 1));
                    hlt = STATE_W'($urandom_range(0, NUM_STATES - 1));
                    blk = SYM_W'($urandom_range(0, NUM_SYMBOLS - 1));
                end
            endcase
            write_setting(CFG_INITIAL_STATE, ini);
            write_setting(CFG_HALTING_STATE, hlt);
            write_setting(CFG_BLANK_SYMBOL, blk);
            queue_programs(CHUNK_ITEMS);
        end

        wait_until_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
